[sv/dsllex_pkg.sv]
// Shared types, character codes, token kinds and the keyword table for the DSL lexer.
// No dependencies; every other file imports this package.
package dsllex_pkg;

   localparam int MAX_TOKEN_LEN = 127;
   localparam int LEN_BITS      = 7;
   localparam int OFFSET_BITS   = 16;
   localparam int KW_PREFIX     = 14;
   localparam int KW_COUNT      = 24;
   localparam int PREFIX_IDX_BITS = $clog2(KW_PREFIX);

   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_SLASH  = 8'h2F;

   localparam logic [5:0] KIND_IDENT   = 6'd0;
   localparam logic [5:0] KIND_NUMBER  = 6'd1;
   localparam logic [5:0] KIND_SYM_BASE = 6'd2;
   localparam logic [5:0] KIND_DIVIDE  = 6'd13;
   localparam logic [5:0] KIND_KW_BASE = 6'd18;

   typedef enum logic [4:0] {
      MODE_IDLE    = 5'b00001,
      MODE_IDENT   = 5'b00010,
      MODE_NUMBER  = 5'b00100,
      MODE_SLASH   = 5'b01000,
      MODE_COMMENT = 5'b10000
   } mode_type;

   typedef logic [KW_PREFIX-1:0][7:0] prefix_type;
   typedef logic [8*KW_PREFIX-1:0]    kw_text_type;

   // One token as delivered on the result channel.
   typedef struct packed {
      logic [5:0]          kind;
      logic [15:0]         start;
      logic [LEN_BITS-1:0] length;
      logic                overflow;
      logic [15:0]         number;
      logic                last;
   } token_type;

   // Tokens produced by one accepted byte, in delivery order.
   typedef struct packed {
      logic [1:0] count;
      token_type  first;
      token_type  second;
   } push_type;

   // Identifier presented to the keyword matcher.
   typedef struct packed {
      prefix_type          text;
      logic [LEN_BITS-1:0] length;
      logic                overflow;
   } name_type;

   typedef struct packed {
      logic       hit;
      logic [3:0] index;
   } sym_type;

   // Keywords, left-aligned and space padded to the prefix width.
   localparam kw_text_type KW_TEXT [KW_COUNT] = '{
      "fn            ", "for           ", "if            ", "return        ",
      "while         ", "sineosc       ", "sawtoothosc   ", "wavetableosc  ",
      "truesineosc   ", "squareosc     ", "triangleosc   ", "randomosc     ",
      "terrainosc    ", "lowpassfilter ", "highpassfilter", "inputa        ",
      "inputb        ", "inputc        ", "inputd        ", "MAIN          ",
      "stepsequencer ", "random        ", "randomint     ", "linenvelope   "
   };

   localparam logic [LEN_BITS-1:0] KW_LEN [KW_COUNT] = '{
      7'd2, 7'd3, 7'd2, 7'd6, 7'd5, 7'd7, 7'd11, 7'd12,
      7'd11, 7'd9, 7'd11, 7'd9, 7'd10, 7'd13, 7'd14, 7'd6,
      7'd6, 7'd6, 7'd6, 7'd4, 7'd13, 7'd6, 7'd9, 7'd11
   };

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic sym_type sym_lookup(input logic [7:0] c);
      sym_type s;
      s.hit = 1'b1;
      unique case (c)
         ";":     s.index = 4'd0;
         "=":     s.index = 4'd1;
         "(":     s.index = 4'd2;
         ")":     s.index = 4'd3;
         "{":     s.index = 4'd4;
         "}":     s.index = 4'd5;
         "[":     s.index = 4'd6;
         "]":     s.index = 4'd7;
         "+":     s.index = 4'd8;
         "-":     s.index = 4'd9;
         "*":     s.index = 4'd10;
         "/":     s.index = 4'd11;
         ">":     s.index = 4'd12;
         "<":     s.index = 4'd13;
         ",":     s.index = 4'd14;
         "$":     s.index = 4'd15;
         default: begin
            s.hit   = 1'b0;
            s.index = 4'd0;
         end
      endcase
      return s;
   endfunction

endpackage

[sv/dsl_lexer_with_keywords_core.sv]
// Top level of the streaming DSL lexer: byte input channel, token output channel.
// Depends on dsllex_pkg, dsllex_scan (with dsllex_kw_match) and dsllex_out_fifo.
//
// Usage:
//   req_*  carries one source byte per item plus end_of_text on the final byte.
//   rsp_*  carries one token per item: kind, start offset, length, overflow
//          flag, running token number and last_of_run, set on the final token
//          that a given byte produced.
//   Both channels: an item moves on a rising edge with valid high, stall low.
// A token is formed in the cycle its terminating byte is accepted, is written
//   into the token queue and is offered on rsp_* once it reaches the head.
// Throughput: one byte per cycle while req_stall is low. A byte that closes
//   one token and opens a symbol (or closes a token at end_of_text) yields
//   two tokens; the queue takes both at once and drains one per cycle while
//   rsp_stall is low; the single output port paces a dense burst of such bytes.
// Stalls: rsp_stall holds the head token steady; req_stall rises when the
//   four-entry token queue has fewer than two free places.
// Reset: synchronous, active high. The scanner returns to idle with offset,
//   token count and length cleared; the queue is emptied.
module dsl_lexer_with_keywords_core import dsllex_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [7:0]          req_source_byte,
   input  logic                req_end_of_text,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [5:0]          rsp_token_kind,
   output logic [15:0]         rsp_start_offset,
   output logic [LEN_BITS-1:0] rsp_token_length,
   output logic                rsp_length_overflow,
   output logic [15:0]         rsp_token_number,
   output logic                rsp_last_of_run
);

   logic      accept;
   logic      queue_full;
   push_type  push;
   token_type head_token;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;

   // Scanner: mode, position, run length and prefix buffer all advance here.
   dsllex_scan u_scan (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .source_byte (req_source_byte),
      .end_of_text (req_end_of_text),
      .push        (push)
   );

   // Result queue decouples token bursts from the receiver's stalls.
   dsllex_out_fifo u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (queue_full),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_token (head_token)
   );

   assign rsp_token_kind      = head_token.kind;
   assign rsp_start_offset    = head_token.start;
   assign rsp_token_length    = head_token.length;
   assign rsp_length_overflow = head_token.overflow;
   assign rsp_token_number    = head_token.number;
   assign rsp_last_of_run     = head_token.last;

endmodule

[sv/dsllex_kw_match.sv]
// Parallel keyword matcher: compares an identifier against all keywords at once.
// Depends on dsllex_pkg for the keyword table and the name type.
module dsllex_kw_match import dsllex_pkg::*; (
   input  name_type   name,
   output logic [5:0] kind
);

   always_comb begin
      logic hit;
      kind = KIND_IDENT;
      for (int i = 0; i < KW_COUNT; i++) begin
         hit = (KW_LEN[i] == name.length) && !name.overflow;
         for (int k = 0; k < KW_PREFIX; k++) begin
            if (k < int'(name.length) &&
                name.text[k] != KW_TEXT[i][8*(KW_PREFIX-1-k) +: 8]) begin
               hit = 1'b0;
            end
         end
         if (hit) begin
            kind = KIND_KW_BASE + 6'(i);
         end
      end
   end

endmodule

[sv/dsllex_scan.sv]
// Scanner state and token formation: one byte per cycle while accept is high, up to two tokens out.
// Depends on dsllex_pkg and dsllex_kw_match.
module dsllex_scan import dsllex_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] source_byte,
   input  logic       end_of_text,
   output push_type   push
);

   mode_type                 mode_ff,   mode_in;
   logic [OFFSET_BITS-1:0]   pos_ff,    pos_in;
   logic [OFFSET_BITS-1:0]   begin_ff,  begin_in;
   logic [LEN_BITS-1:0]      len_ff,    len_in;
   logic                     ovf_ff,    ovf_in;
   logic [15:0]              count_ff,  count_in;
   prefix_type               prefix_ff, prefix_in;

   logic       fresh;
   logic       flush_a, ident_a, emit_b, flush_c, ident_c;
   logic [5:0] kind_a, kind_b, kind_c, kw_kind;
   sym_type    sym;
   name_type   name;
   token_type  tok_a, tok_b, tok_c, tok_first, tok_second;
   logic [1:0] n_emit;

   assign sym = sym_lookup(source_byte);

   always_comb begin
      mode_in   = mode_ff;
      pos_in    = pos_ff;
      begin_in  = begin_ff;
      len_in    = len_ff;
      ovf_in    = ovf_ff;
      prefix_in = prefix_ff;
      fresh     = 1'b1;
      flush_a   = 1'b0;
      ident_a   = 1'b0;
      kind_a    = KIND_NUMBER;
      emit_b    = 1'b0;
      kind_b    = KIND_SYM_BASE + {2'b00, sym.index};
      flush_c   = 1'b0;
      ident_c   = 1'b0;
      kind_c    = KIND_NUMBER;

      if (accept) begin
         unique case (mode_ff)
            MODE_COMMENT: begin
               if (source_byte == CH_LF) mode_in = MODE_IDLE;
               fresh = 1'b0;
            end
            MODE_SLASH: begin
               if (source_byte == CH_SLASH) begin
                  mode_in = MODE_COMMENT;
                  fresh   = 1'b0;
               end else begin
                  flush_a = 1'b1;
                  kind_a  = KIND_DIVIDE;
                  mode_in = MODE_IDLE;
               end
            end
            MODE_IDENT, MODE_NUMBER: begin
               if ((mode_ff == MODE_IDENT &&
                    (is_alpha(source_byte) || is_digit(source_byte) ||
                     source_byte == CH_HASH)) ||
                   (mode_ff == MODE_NUMBER &&
                    (is_digit(source_byte) || source_byte == CH_DOT))) begin
                  fresh = 1'b0;
                  if (len_ff < LEN_BITS'(MAX_TOKEN_LEN)) begin
                     if (len_ff < LEN_BITS'(KW_PREFIX)) begin
                        prefix_in[len_ff[PREFIX_IDX_BITS-1:0]] = source_byte;
                     end
                     len_in = len_ff + 1'b1;
                  end else begin
                     ovf_in = 1'b1;
                  end
               end else begin
                  flush_a = 1'b1;
                  ident_a = (mode_ff == MODE_IDENT);
                  mode_in = MODE_IDLE;
               end
            end
            default: ;
         endcase

         if (fresh) begin
            if (is_alpha(source_byte) || is_digit(source_byte) ||
                source_byte == CH_SLASH || sym.hit) begin
               begin_in     = pos_ff;
               len_in       = LEN_BITS'(1);
               ovf_in       = 1'b0;
               prefix_in[0] = source_byte;
            end
            if (is_alpha(source_byte))          mode_in = MODE_IDENT;
            else if (is_digit(source_byte))     mode_in = MODE_NUMBER;
            else if (source_byte == CH_SLASH)   mode_in = MODE_SLASH;
            else if (sym.hit)                   emit_b  = 1'b1;
         end

         if (end_of_text) begin
            flush_c = (mode_in == MODE_IDENT) || (mode_in == MODE_NUMBER) ||
                      (mode_in == MODE_SLASH);
            ident_c = (mode_in == MODE_IDENT);
            if (mode_in == MODE_SLASH) kind_c = KIND_DIVIDE;
            mode_in = MODE_IDLE;
            pos_in  = '0;
         end else if (pos_ff != '1) begin
            pos_in = pos_ff + 1'b1;
         end
      end
   end

   // Only one identifier can end per byte, so one matcher serves both flush points.
   always_comb begin
      if (ident_a) begin
         name.text     = prefix_ff;
         name.length   = len_ff;
         name.overflow = ovf_ff;
      end else begin
         name.text     = prefix_in;
         name.length   = len_in;
         name.overflow = ovf_in;
      end
   end

   dsllex_kw_match u_kw_match (
      .name (name),
      .kind (kw_kind)
   );

   always_comb begin
      tok_a          = '0;
      tok_a.kind     = ident_a ? kw_kind : kind_a;
      tok_a.start    = begin_ff[15:0];
      tok_a.length   = len_ff;
      tok_a.overflow = ovf_ff;

      tok_b          = '0;
      tok_b.kind     = kind_b;
      tok_b.start    = pos_ff[15:0];
      tok_b.length   = LEN_BITS'(1);

      tok_c          = '0;
      tok_c.kind     = ident_c ? kw_kind : kind_c;
      tok_c.start    = begin_in[15:0];
      tok_c.length   = len_in;
      tok_c.overflow = ovf_in;

      n_emit = 2'({1'b0, flush_a} + {1'b0, emit_b} + {1'b0, flush_c});

      tok_first         = flush_a ? tok_a : (emit_b ? tok_b : tok_c);
      tok_first.number  = count_ff;
      tok_first.last    = (n_emit == 2'd1);
      tok_second        = emit_b ? tok_b : tok_c;
      tok_second.number = count_ff + 16'd1;
      tok_second.last   = 1'b1;

      push.count  = n_emit;
      push.first  = tok_first;
      push.second = tok_second;

      count_in = count_ff;
      if (accept) begin
         count_in = end_of_text ? 16'd0 : count_ff + {14'd0, n_emit};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         pos_ff   <= '0;
         begin_ff <= '0;
         len_ff   <= '0;
         ovf_ff   <= 1'b0;
         count_ff <= '0;
      end else begin
         mode_ff  <= mode_in;
         pos_ff   <= pos_in;
         begin_ff <= begin_in;
         len_ff   <= len_in;
         ovf_ff   <= ovf_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      prefix_ff <= prefix_in;
   end

   a_two_needs_flush: assert property (@(posedge clock) disable iff (reset)
      (push.count == 2'd2) |-> flush_a)
      else $error("two tokens from one byte without a pending token");

   a_no_push_idle: assert property (@(posedge clock) disable iff (reset)
      !accept |-> (push.count == 2'd0))
      else $error("token formed without an accepted byte");

   a_eot_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && end_of_text) |=> (mode_ff == MODE_IDLE && pos_ff == '0 && count_ff == '0))
      else $error("end of text did not return scanner to start");

endmodule

[sv/dsllex_out_fifo.sv]
// Four-entry token queue: takes up to two tokens per cycle, hands out one per cycle while out_stall is low.
// Depends on dsllex_pkg for the token and push types.
module dsllex_out_fifo import dsllex_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  push_type  push,
   output logic      full,
   output logic      out_valid,
   input  logic      out_stall,
   output token_type out_token
);

   localparam int DEPTH    = 4;
   localparam int PTR_BITS = $clog2(DEPTH);
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   token_type             entry_ff [DEPTH];
   logic [PTR_BITS-1:0]   head_ff, head_in;
   logic [PTR_BITS-1:0]   tail_ff, tail_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic                  pop;

   // Room for a full two-token burst is required before a byte is taken.
   assign full      = count_ff > CNT_BITS'(DEPTH - 2);
   assign out_valid = count_ff != '0;
   assign out_token = entry_ff[head_ff];
   assign pop       = out_valid && !out_stall;

   always_comb begin
      head_in  = pop ? head_ff + 1'b1 : head_ff;
      tail_in  = tail_ff + PTR_BITS'(push.count);
      count_in = count_ff + CNT_BITS'(push.count) - CNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[tail_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entry_ff[tail_ff + 1'b1] <= push.second;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(DEPTH))
      else $error("token queue overfilled");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      (push.count != 2'd0) |-> !full)
      else $error("tokens pushed while queue lacks room");

   a_pop_only: assert property (@(posedge clock) disable iff (reset)
      (pop && push.count == 2'd0) |=> (count_ff == $past(count_ff) - 1'b1))
      else $error("queue count wrong after pop");

endmodule
